FILE: src/rss_pkg.sv
package rss_pkg;

  // Field widths of the word and of the result
  localparam int SAMPLE_W = 24;
  localparam int COUNT_W  = 16;
  localparam int SUM_W    = 40;
  localparam int SQ_W     = 64;
  // Width of the shared add/subtract unit and of the working registers
  localparam int WIDE_W   = 80;
  // n * (n - 1) fits in this many bits
  localparam int DIV_W    = 2 * COUNT_W;

  // Operation codes
  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REPORT = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // Step counts of the report sequence
  localparam int MEAN_STEPS  = SUM_W;
  localparam int MULN_STEPS  = COUNT_W;
  localparam int MULS_STEPS  = SUM_W;
  localparam int VDIV_STEPS  = WIDE_W;
  localparam int SQRT_STEPS  = SQ_W / 2;
  localparam int STEP_W      = 7;

  // Accumulated statistics, as seen by the report sequencer and the output
  typedef struct packed {
    logic [COUNT_W-1:0]  count;
    logic [SUM_W-1:0]    sum;
    logic [SQ_W-1:0]     square_sum;
    logic [SAMPLE_W-1:0] min_v;
    logic [SAMPLE_W-1:0] max_v;
    logic                saturated;
  } rss_stats_t;

  // Report sequencer status
  typedef struct packed {
    logic                busy;
    logic                done;
    logic [SAMPLE_W-1:0] mean;
    logic [SAMPLE_W-1:0] std;
  } rss_rep_t;

endpackage

FILE: src/rss_alu.sv
module rss_alu (
  input  logic [rss_pkg::WIDE_W-1:0] a,
  input  logic [rss_pkg::WIDE_W-1:0] b,
  input  logic                       sub,
  output logic [rss_pkg::WIDE_W-1:0] res,
  output logic                       ge
);

  localparam int WW = rss_pkg::WIDE_W;
  localparam int FW = WW + 1;

  logic [WW:0] full;

  // a + b, or a - b with carry out meaning a >= b
  assign full = {1'b0, a} + {1'b0, (sub ? ~b : b)} + FW'(sub);
  assign res  = full[WW-1:0];
  assign ge   = full[WW];

endmodule

FILE: src/rss_accum.sv
module rss_accum #(
  parameter int COUNT_BITS  = 16,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         add_go,
  input  logic                         clear_go,
  input  logic [rss_pkg::SAMPLE_W-1:0] sample_value,
  output logic                         busy,
  output rss_pkg::rss_stats_t          stats
);

  localparam int SW = rss_pkg::SAMPLE_W;
  localparam int CW = rss_pkg::COUNT_W;
  localparam int UW = rss_pkg::SUM_W;
  localparam int QW = rss_pkg::SQ_W;
  localparam logic [COUNT_BITS-1:0] COUNT_FULL = '1;

  logic signed [SAMPLE_BITS-1:0] smp_raw;
  logic signed [SW-1:0]          smp_ext;
  logic signed [2*SW-1:0]        sq_full;
  logic signed [SW-1:0]          smp;
  logic [2*SW-2:0]               sq;
  logic                          pend;
  logic [COUNT_BITS-1:0]         count;
  logic signed [UW-1:0]          sum;
  logic [QW-1:0]                 square_sum;
  logic signed [SW-1:0]          min_v;
  logic signed [SW-1:0]          max_v;
  logic                          saturated;

  // Sample is the low SAMPLE_BITS of the port, sign-extended
  assign smp_raw = sample_value[SAMPLE_BITS-1:0];
  assign smp_ext = SW'(smp_raw);
  assign sq_full = smp_ext * smp_ext;

  // Capture sample and its square at accept
  always_ff @(posedge clk) begin
    if (add_go) begin
      smp <= smp_ext;
      sq  <= sq_full[2*SW-2:0];
    end
  end

  // Fold the captured sample into the running state in the cycle after the capture
  always_ff @(posedge clk) begin
    if (rst || clear_go) begin
      pend       <= 1'b0;
      count      <= '0;
      sum        <= '0;
      square_sum <= '0;
      min_v      <= '0;
      max_v      <= '0;
      saturated  <= 1'b0;
    end else if (add_go) begin
      pend <= 1'b1;
    end else if (pend) begin
      pend <= 1'b0;
      if (count == COUNT_FULL) begin
        saturated <= 1'b1;
      end else begin
        count      <= count + 1'b1;
        sum        <= sum + UW'(smp);
        square_sum <= square_sum + QW'(sq);
        if (count == '0) begin
          min_v <= smp;
          max_v <= smp;
        end else begin
          if (smp < min_v) min_v <= smp;
          if (smp > max_v) max_v <= smp;
        end
      end
    end
  end

  assign busy             = pend;
  assign stats.count      = CW'(count);
  assign stats.sum        = sum;
  assign stats.square_sum = square_sum;
  assign stats.min_v      = min_v;
  assign stats.max_v      = max_v;
  assign stats.saturated  = saturated;

endmodule

FILE: src/rss_seq.sv
module rss_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                take,
  input  rss_pkg::rss_stats_t stats,
  output rss_pkg::rss_rep_t   rep
);

  localparam int WW = rss_pkg::WIDE_W;
  localparam int SW = rss_pkg::SAMPLE_W;
  localparam int UW = rss_pkg::SUM_W;
  localparam int QW = rss_pkg::SQ_W;
  localparam int DW = rss_pkg::DIV_W;
  localparam int TW = rss_pkg::STEP_W;
  localparam logic [WW-1:0] SQRT_BIT0 = WW'(1) << (QW - 2);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_MEAN  = 9'b000000010,
    S_MUL_A = 9'b000000100,
    S_MUL_B = 9'b000001000,
    S_DIFF  = 9'b000010000,
    S_MUL_C = 9'b000100000,
    S_VDIV  = 9'b001000000,
    S_SQRT  = 9'b010000000,
    S_DONE  = 9'b100000000
  } rss_state_t;

  rss_state_t      state, state_next;
  logic [WW-1:0]   ra, ra_next;   // product / remainder / radicand
  logic [WW-1:0]   rb, rb_next;   // multiplicand / mean quotient / root
  logic [WW-1:0]   rc, rc_next;   // held product / variance quotient / root bit
  logic [UW-1:0]   rq, rq_next;   // multiplier bits
  logic [DW-1:0]   dv, dv_next;   // n * (n - 1)
  logic [TW-1:0]   cnt, cnt_next;
  logic [SW-1:0]   mean, mean_next;
  logic [SW-1:0]   std, std_next;

  logic [WW-1:0]   alu_a, alu_b, alu_res;
  logic            alu_sub, alu_ge;

  logic            sum_neg;
  logic [UW-1:0]   sum_mag;
  logic [rss_pkg::COUNT_W-1:0] n;

  assign n       = stats.count;
  assign sum_neg = stats.sum[UW-1];
  assign sum_mag = sum_neg ? (~stats.sum + 1'b1) : stats.sum;

  // Operand selection for the shared unit
  always_comb begin
    alu_a   = ra;
    alu_b   = rb;
    alu_sub = 1'b0;
    case (state)
      S_MEAN: begin
        alu_a   = {ra[WW-2:0], rb[UW-1]};
        alu_b   = WW'(n);
        alu_sub = 1'b1;
      end
      S_DIFF: begin
        alu_a   = rc;
        alu_b   = ra;
        alu_sub = 1'b1;
      end
      S_VDIV: begin
        alu_a   = {ra[WW-2:0], rc[WW-1]};
        alu_b   = WW'(dv);
        alu_sub = 1'b1;
      end
      S_SQRT: begin
        alu_a   = ra;
        alu_b   = rb | rc;
        alu_sub = 1'b1;
      end
      default: ;
    endcase
  end

  rss_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .res (alu_res),
    .ge  (alu_ge)
  );

  // Sequencer
  always_comb begin
    logic [WW-1:0] prod;
    logic [WW-1:0] shl;
    logic [SW-1:0] quo_lo;
    logic          last;

    prod       = rq[0] ? alu_res : ra;
    shl        = {rc[WW-2:0], alu_ge};
    quo_lo     = {rb[SW-2:0], alu_ge};
    last       = (cnt == '0);

    state_next = state;
    ra_next    = ra;
    rb_next    = rb;
    rc_next    = rc;
    rq_next    = rq;
    dv_next    = dv;
    cnt_next   = cnt - 1'b1;
    mean_next  = mean;
    std_next   = std;

    case (state)
      S_IDLE: begin
        cnt_next = cnt;
        if (start) begin
          mean_next = '0;
          std_next  = '0;
          if (n == '0) begin
            state_next = S_DONE;
          end else begin
            state_next = S_MEAN;
            ra_next    = '0;
            rb_next    = WW'(sum_mag);
            cnt_next   = TW'(rss_pkg::MEAN_STEPS - 1);
          end
        end
      end
      // |sum| / n, restoring, one quotient bit a cycle
      S_MEAN: begin
        ra_next = alu_ge ? alu_res : alu_a;
        rb_next = {rb[WW-2:0], alu_ge};
        if (last) begin
          mean_next = sum_neg ? (~quo_lo + 1'b1) : quo_lo;
          if (n == rss_pkg::COUNT_W'(1)) begin
            state_next = S_DONE;
          end else begin
            state_next = S_MUL_A;
            ra_next    = '0;
            rb_next    = WW'(stats.square_sum);
            rq_next    = UW'(n);
            cnt_next   = TW'(rss_pkg::MULN_STEPS - 1);
          end
        end
      end
      // n * sumsq, shift and add
      S_MUL_A: begin
        ra_next = prod;
        rb_next = rb << 1;
        rq_next = rq >> 1;
        if (last) begin
          state_next = S_MUL_B;
          rc_next    = prod;
          ra_next    = '0;
          rb_next    = WW'(sum_mag);
          rq_next    = sum_mag;
          cnt_next   = TW'(rss_pkg::MULS_STEPS - 1);
        end
      end
      // sum^2, shift and add
      S_MUL_B: begin
        ra_next = prod;
        rb_next = rb << 1;
        rq_next = rq >> 1;
        if (last) state_next = S_DIFF;
      end
      // n * sumsq - sum^2
      S_DIFF: begin
        cnt_next = cnt;
        if (alu_ge) begin
          state_next = S_MUL_C;
          rc_next    = alu_res;
          ra_next    = '0;
          rb_next    = WW'(n);
          rq_next    = UW'(n - 1'b1);
          cnt_next   = TW'(rss_pkg::MULN_STEPS - 1);
        end else begin
          state_next = S_DONE;
        end
      end
      // n * (n - 1), shift and add
      S_MUL_C: begin
        ra_next = prod;
        rb_next = rb << 1;
        rq_next = rq >> 1;
        if (last) begin
          state_next = S_VDIV;
          dv_next    = prod[DW-1:0];
          ra_next    = '0;
          cnt_next   = TW'(rss_pkg::VDIV_STEPS - 1);
        end
      end
      // variance quotient, restoring, one bit a cycle
      S_VDIV: begin
        ra_next = alu_ge ? alu_res : alu_a;
        rc_next = shl;
        if (last) begin
          state_next = S_SQRT;
          ra_next    = WW'(shl[QW-1:0]);
          rb_next    = '0;
          rc_next    = SQRT_BIT0;
          cnt_next   = TW'(rss_pkg::SQRT_STEPS - 1);
        end
      end
      // integer square root, two radicand bits a cycle
      S_SQRT: begin
        if (alu_ge) begin
          ra_next = alu_res;
          rb_next = (rb >> 1) | rc;
        end else begin
          rb_next = rb >> 1;
        end
        rc_next = rc >> 2;
        if (last) begin
          state_next = S_DONE;
          std_next   = rb_next[SW-1:0];
        end
      end
      S_DONE: begin
        cnt_next = cnt;
        if (take) state_next = S_IDLE;
      end
      default: begin
        cnt_next   = cnt;
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    ra   <= ra_next;
    rb   <= rb_next;
    rc   <= rc_next;
    rq   <= rq_next;
    dv   <= dv_next;
    mean <= mean_next;
    std  <= std_next;
  end

  assign rep.busy = (state != S_IDLE);
  assign rep.done = (state == S_DONE);
  assign rep.mean = mean;
  assign rep.std  = std;

endmodule

FILE: src/running_sample_statistics.sv
// Running sample statistics: accumulates signed Q16.8 samples (op 0), reports
// count, mean, sample standard deviation, min, max, sum and sum of squares
// (op 1), and clears all state including the sticky saturated flag (op 2);
// op 3 is taken and ignored. An add captures the sample with the squaring
// multiplier, then does the accumulate; a clear or op 3 leaves the input
// ready. A report runs through one shared 80-bit add/subtract unit: a
// 40-step mean divide, 16- and 40-step shift-add multiplies for n*sumsq and
// sum^2, one subtract, a 16-step multiply for n*(n-1), an 80-step variance
// divide and a 32-step square root; when the count is 1 only the mean divide
// runs, and when it is 0 none of them do. The input is not ready while an
// add or a report is in progress. A finished report moves into the output
// register as soon as that register is free and then no longer blocks input;
// while an earlier word still waits there, the input stays not ready. When
// the count reaches 2^COUNT_BITS-1, further samples are dropped and the flag
// is set.
module running_sample_statistics #(
  parameter int COUNT_BITS  = 16,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_ready,
  input  logic [1:0]                   op,
  input  logic [rss_pkg::SAMPLE_W-1:0] sample_value,
  output logic                         result_valid,
  input  logic                         result_ready,
  output logic [rss_pkg::COUNT_W-1:0]  sample_count,
  output logic [rss_pkg::SAMPLE_W-1:0] mean_value,
  output logic [rss_pkg::SAMPLE_W-1:0] std_deviation,
  output logic [rss_pkg::SAMPLE_W-1:0] min_value,
  output logic [rss_pkg::SAMPLE_W-1:0] max_value,
  output logic [rss_pkg::SUM_W-1:0]    total_sum,
  output logic [rss_pkg::SQ_W-1:0]     total_square_sum,
  output logic                         saturated_flag
);

  rss_pkg::rss_stats_t stats;
  rss_pkg::rss_rep_t   rep;
  logic                acc_busy;
  logic                accept;
  logic                out_load;

  assign item_ready = !acc_busy && !rep.busy;
  assign accept     = item_valid && item_ready;
  assign out_load   = rep.done && (!result_valid || result_ready);

  rss_accum #(
    .COUNT_BITS  (COUNT_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_accum (
    .clk          (clk),
    .rst          (rst),
    .add_go       (accept && (op == rss_pkg::OP_ADD)),
    .clear_go     (accept && (op == rss_pkg::OP_CLEAR)),
    .sample_value (sample_value),
    .busy         (acc_busy),
    .stats        (stats)
  );

  rss_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (accept && (op == rss_pkg::OP_REPORT)),
    .take  (out_load),
    .stats (stats),
    .rep   (rep)
  );

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      sample_count     <= stats.count;
      mean_value       <= rep.mean;
      std_deviation    <= rep.std;
      min_value        <= stats.min_v;
      max_value        <= stats.max_v;
      total_sum        <= stats.sum;
      total_square_sum <= stats.square_sum;
      saturated_flag   <= stats.saturated;
    end
  end

endmodule

FILE: src/rss_checker.sv
module rss_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         item_valid,
  input logic                         item_ready,
  input logic [1:0]                   op,
  input logic [rss_pkg::SAMPLE_W-1:0] sample_value,
  input logic                         result_valid,
  input logic                         result_ready,
  input logic [rss_pkg::COUNT_W-1:0]  sample_count,
  input logic [rss_pkg::SAMPLE_W-1:0] mean_value,
  input logic [rss_pkg::SAMPLE_W-1:0] std_deviation,
  input logic [rss_pkg::SAMPLE_W-1:0] min_value,
  input logic [rss_pkg::SAMPLE_W-1:0] max_value,
  input logic [rss_pkg::SUM_W-1:0]    total_sum,
  input logic [rss_pkg::SQ_W-1:0]     total_square_sum,
  input logic                         saturated_flag
);

  // A result word holds until taken
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(std_deviation))
    else $error("result word dropped or changed while stalled");

  // Minimum never exceeds maximum once samples exist
  a_min_max: assert property (@(posedge clk) disable iff (rst)
    result_valid && (sample_count != '0) |->
      $signed(min_value) <= $signed(max_value))
    else $error("min above max");

  // Deviation is zero below two samples
  a_std_small: assert property (@(posedge clk) disable iff (rst)
    result_valid && (sample_count == '0 || sample_count == 16'd1) |->
      std_deviation == '0)
    else $error("nonzero deviation with fewer than two samples");

  // An empty accumulator reports all zeros
  a_empty: assert property (@(posedge clk) disable iff (rst)
    result_valid && (sample_count == '0) |->
      mean_value == '0 && total_sum == '0 && total_square_sum == '0 &&
      min_value == '0 && max_value == '0)
    else $error("empty accumulator reports nonzero values");

endmodule

bind running_sample_statistics rss_checker u_rss_checker (.*);

FILE: test/tb_running_sample_statistics.sv
module tb_running_sample_statistics;
  import rss_pkg::*;

  // op 3 has no name in the package; the block takes it and does nothing
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [15:0] COUNT_FULL = 16'hFFFF;
  localparam int DRAIN_CYCLES = 300;

  // One report word as the block should present it
  typedef struct {
    logic [COUNT_W-1:0]  count;
    logic [SAMPLE_W-1:0] mean;
    logic [SAMPLE_W-1:0] std;
    logic [SAMPLE_W-1:0] min_v;
    logic [SAMPLE_W-1:0] max_v;
    logic [SUM_W-1:0]    sum;
    logic [SQ_W-1:0]     square_sum;
    logic                saturated;
  } stats_word_t;

  logic                clk;
  logic                rst;
  logic                item_valid;
  logic                item_ready;
  logic [1:0]          op;
  logic [SAMPLE_W-1:0] sample_value;
  logic                result_valid;
  logic                result_ready;
  logic [COUNT_W-1:0]  sample_count;
  logic [SAMPLE_W-1:0] mean_value;
  logic [SAMPLE_W-1:0] std_deviation;
  logic [SAMPLE_W-1:0] min_value;
  logic [SAMPLE_W-1:0] max_value;
  logic [SUM_W-1:0]    total_sum;
  logic [SQ_W-1:0]     total_square_sum;
  logic                saturated_flag;

  running_sample_statistics DUT (
    .clk              (clk),
    .rst              (rst),
    .item_valid       (item_valid),
    .item_ready       (item_ready),
    .op               (op),
    .sample_value     (sample_value),
    .result_valid     (result_valid),
    .result_ready     (result_ready),
    .sample_count     (sample_count),
    .mean_value       (mean_value),
    .std_deviation    (std_deviation),
    .min_value        (min_value),
    .max_value        (max_value),
    .total_sum        (total_sum),
    .total_square_sum (total_square_sum),
    .saturated_flag   (saturated_flag)
  );

  // Accumulator state mirrored in the testbench
  logic [COUNT_W-1:0]         acc_count;
  logic signed [SUM_W-1:0]    acc_sum;
  logic [SQ_W-1:0]            acc_square_sum;
  logic signed [SAMPLE_W-1:0] acc_min;
  logic signed [SAMPLE_W-1:0] acc_max;
  logic                       acc_saturated;

  stats_word_t pending_reports[$];
  int          mismatch_count;
  int          failure_count;
  bit          gaps_on;
  bit          stall_on;
  int          hold_left;
  logic [SAMPLE_W-1:0] last_sample;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    #20000000;
    $display("Test completed with failures");
    $finish;
  end

  // Integer square root, one result bit per pass
  function automatic logic [31:0] floor_sqrt(input logic [63:0] v);
    logic [31:0] r;
    logic [31:0] cand;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      cand = r | (32'd1 << b);
      if ({32'd0, cand} * {32'd0, cand} <= v) r = cand;
    end
    return r;
  endfunction

  // Sample standard deviation from the running sums
  function automatic logic [SAMPLE_W-1:0] sample_std();
    logic [127:0] n_sumsq;
    logic [127:0] sum_sq;
    logic [127:0] quotient;
    logic [63:0]  sum_mag;
    longint       sum_l;
    if (acc_count < 2) return '0;
    sum_l   = longint'(acc_sum);
    sum_mag = (sum_l < 0) ? 64'(-sum_l) : 64'(sum_l);
    n_sumsq = 128'(acc_count) * 128'(acc_square_sum);
    sum_sq  = 128'(sum_mag) * 128'(sum_mag);
    if (n_sumsq < sum_sq) return '0;
    quotient = (n_sumsq - sum_sq) / (128'(acc_count) * 128'(acc_count - 16'd1));
    return SAMPLE_W'(floor_sqrt(quotient[63:0]));
  endfunction

  function automatic void clear_stats();
    acc_count      = '0;
    acc_sum        = '0;
    acc_square_sum = '0;
    acc_min        = '0;
    acc_max        = '0;
    acc_saturated  = 1'b0;
  endfunction

  // Apply one accepted word to the mirrored state; a report queues its result
  function automatic void apply_word(input logic [1:0] o, input logic [SAMPLE_W-1:0] v);
    logic signed [SAMPLE_W-1:0] s;
    longint                     s_l;
    stats_word_t                w;
    s   = v;
    s_l = longint'(s);
    case (o)
      OP_ADD: begin
        if (acc_count == COUNT_FULL) begin
          acc_saturated = 1'b1;
        end else begin
          if (acc_count == 0 || s < acc_min) acc_min = s;
          if (acc_count == 0 || s > acc_max) acc_max = s;
          acc_count      = acc_count + 16'd1;
          acc_sum        = acc_sum + SUM_W'(s_l);
          acc_square_sum = acc_square_sum + 64'(s_l * s_l);
        end
      end
      OP_REPORT: begin
        w.count      = acc_count;
        w.mean       = (acc_count == 0) ? '0 :
                       SAMPLE_W'(longint'(acc_sum) / longint'(acc_count));
        w.std        = sample_std();
        w.min_v      = acc_min;
        w.max_v      = acc_max;
        w.sum        = acc_sum;
        w.square_sum = acc_square_sum;
        w.saturated  = acc_saturated;
        pending_reports.push_back(w);
      end
      OP_CLEAR: clear_stats();
      default: ;
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [63:0] exp_v,
                                      input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      mismatch_count++;
      failure_count++;
      if (mismatch_count <= 10)
        $display("mismatch on %s: expected %h, got %h", name, exp_v, act_v);
    end
  endfunction

  // Result checker
  always @(posedge clk) begin
    stats_word_t w;
    if (!rst && result_valid && result_ready) begin
      if (pending_reports.size() == 0) begin
        failure_count++;
        $display("unexpected result word, count %0d", sample_count);
      end else begin
        w = pending_reports.pop_front();
        check_field("sample_count", 64'(w.count), 64'(sample_count));
        check_field("mean_value", 64'(w.mean), 64'(mean_value));
        check_field("std_deviation", 64'(w.std), 64'(std_deviation));
        check_field("min_value", 64'(w.min_v), 64'(min_value));
        check_field("max_value", 64'(w.max_v), 64'(max_value));
        check_field("total_sum", 64'(w.sum), 64'(total_sum));
        check_field("total_square_sum", w.square_sum, total_square_sum);
        check_field("saturated_flag", 64'(w.saturated), 64'(saturated_flag));
      end
    end
  end

  // Result sink: holds off while hold_left runs down, then random stall bursts when enabled
  initial begin
    int burst;
    burst = 0;
    result_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        result_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else if (burst > 0) begin
        burst--;
        result_ready <= 1'b0;
      end else if (stall_on && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(0, 4);
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  // Offer one word, with an optional gap in front, and wait for it to be taken
  task automatic send_word(input logic [1:0] o, input logic [SAMPLE_W-1:0] v);
    int gap;
    gap = (gaps_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
    @(negedge clk);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid   <= 1'b1;
    op           <= o;
    sample_value <= v;
    do @(posedge clk); while (!item_ready);
    apply_word(o, v);
  endtask

  // Stop offering and wait until every report has come back
  task automatic wait_reports();
    @(negedge clk);
    item_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  function automatic logic [SAMPLE_W-1:0] next_sample();
    logic [SAMPLE_W-1:0] v;
    case ($urandom_range(0, 5))
      0, 1: v = SAMPLE_W'($urandom);
      2:    v = SAMPLE_W'($urandom_range(0, 2000) - 1000);
      3: begin
        case ($urandom_range(0, 3))
          0: v = 24'h7FFFFF;
          1: v = 24'h800000;
          2: v = 24'h000000;
          default: v = 24'hFFFFFF;
        endcase
      end
      4:    v = last_sample;
      default: v = last_sample + SAMPLE_W'($urandom_range(0, 16) - 8);
    endcase
    last_sample = v;
    return v;
  endfunction

  // Reports on an empty accumulator, ignored op, clear on empty
  task automatic test_empty_state();
    send_word(OP_REPORT, 24'h123456);
    send_word(OP_UNUSED, 24'h7FFFFF);
    send_word(OP_CLEAR, 24'h800000);
    send_word(OP_REPORT, 24'h000000);
  endtask

  // One sample (min and max both set by it, no deviation yet), then a second
  task automatic test_single_sample();
    send_word(OP_ADD, 24'hFFFF80);
    send_word(OP_REPORT, 24'h0);
    send_word(OP_ADD, 24'h000180);
    send_word(OP_REPORT, 24'h0);
    send_word(OP_CLEAR, 24'h0);
  endtask

  // Field extremes, negative mean truncation and a zero-variance run
  task automatic test_extreme_samples();
    send_word(OP_ADD, 24'h7FFFFF);
    send_word(OP_ADD, 24'h800000);
    send_word(OP_ADD, 24'h000000);
    send_word(OP_ADD, 24'hFFFFFF);
    send_word(OP_REPORT, 24'h0);
    send_word(OP_ADD, 24'h800000);
    send_word(OP_REPORT, 24'h0);
    send_word(OP_CLEAR, 24'h0);
    send_word(OP_ADD, 24'h000301);
    send_word(OP_ADD, 24'h000301);
    send_word(OP_ADD, 24'h000301);
    send_word(OP_REPORT, 24'h0);
    send_word(OP_CLEAR, 24'h0);
  endtask

  // Receiver holds off while the sender keeps going, then the sender pauses
  task automatic test_long_stall();
    hold_left = 600;
    for (int i = 0; i < 8; i++) send_word(OP_ADD, next_sample());
    send_word(OP_REPORT, 24'h0);
    for (int i = 0; i < 4; i++) send_word(OP_ADD, next_sample());
    send_word(OP_REPORT, 24'h0);
    send_word(OP_REPORT, 24'h0);
    for (int i = 0; i < 4; i++) send_word(OP_ADD, next_sample());
    send_word(OP_REPORT, 24'h0);
    wait_reports();
    send_word(OP_CLEAR, 24'h0);
  endtask

  // Runs of samples closed by a report, some clears, a little ignored noise
  task automatic test_random_mix();
    int sent;
    int run_len;
    sent = 0;
    while (sent < 1850) begin
      gaps_on  = ((sent / 300) % 3) != 2;
      stall_on = gaps_on;
      run_len  = $urandom_range(0, 24);
      for (int i = 0; i < run_len; i++) begin
        if ($urandom_range(0, 49) == 0) begin
          send_word(OP_UNUSED, SAMPLE_W'($urandom));
        end else begin
          send_word(OP_ADD, next_sample());
          sent++;
        end
      end
      send_word(OP_REPORT, SAMPLE_W'($urandom));
      sent++;
      if ($urandom_range(0, 5) == 0) begin
        send_word(OP_CLEAR, SAMPLE_W'($urandom));
        sent++;
      end
    end
  endtask

  // Closing run with no idling on either side, ended by a clear and a report
  task automatic test_back_to_back();
    gaps_on  = 1'b0;
    stall_on = 1'b0;
    send_word(OP_CLEAR, 24'h0);
    for (int i = 0; i < 40; i++) send_word(OP_ADD, next_sample());
    send_word(OP_REPORT, 24'h0);
    send_word(OP_ADD, 24'h7FFFFF);
    send_word(OP_REPORT, 24'h0);
    send_word(OP_ADD, 24'h800000);
    send_word(OP_REPORT, 24'h0);
    send_word(OP_CLEAR, 24'h0);
    send_word(OP_REPORT, 24'h0);
  endtask

  // Main sequence
  initial begin
    rst            = 1'b1;
    item_valid     = 1'b0;
    op             = OP_ADD;
    sample_value   = '0;
    mismatch_count = 0;
    failure_count  = 0;
    gaps_on        = 1'b1;
    stall_on       = 1'b1;
    hold_left      = 0;
    last_sample    = '0;
    clear_stats();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_state();
    test_single_sample();
    test_extreme_samples();
    test_long_stall();
    test_random_mix();
    test_back_to_back();

    wait_reports();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_reports.size() != 0) failure_count++;
    if (failure_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/rss_pkg.sv
src/rss_alu.sv
src/rss_accum.sv
src/rss_seq.sv
src/running_sample_statistics.sv
src/rss_checker.sv
test/tb_running_sample_statistics.sv
